// File: design/x86am_pkg.sv
// Shared types for the ModR/M / SIB effective address decoder.
// Holds the operand record handed from the parser to the address stage
// and the register file write request. No dependencies.
package x86am_pkg;

  localparam int unsigned REG_W = 32;

  typedef struct packed {
    logic             en;
    logic [2:0]       sel;
    logic [REG_W-1:0] data;
  } gpr_wr_t;

  typedef struct packed {
    logic             is_memory;
    logic [2:0]       reg_field;
    logic [2:0]       rm_register;
    logic [2:0]       byte_length;
    logic [REG_W-1:0] disp;
    logic             base_en;
    logic [2:0]       base_sel;
    logic             index_en;
    logic [2:0]       index_sel;
    logic [1:0]       scale;
  } op_rec_t;

endpackage

// File: design/x86am_regfile.sv
// Copy of the eight 32-bit general registers: one write port and two
// registered read ports for base and index. Depends on x86am_pkg.
module x86am_regfile (
  input  logic                         clk,
  input  logic                         rst_n,
  input  x86am_pkg::gpr_wr_t           wr,
  input  logic                         rd_en,
  input  logic [2:0]                   rd_base_sel,
  input  logic [2:0]                   rd_index_sel,
  output logic [x86am_pkg::REG_W-1:0]  rd_base,
  output logic [x86am_pkg::REG_W-1:0]  rd_index
);

  logic [x86am_pkg::REG_W-1:0] gpr_r [8];
  logic [x86am_pkg::REG_W-1:0] rd_base_r;
  logic [x86am_pkg::REG_W-1:0] rd_index_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        gpr_r[i] <= '0;
      end
    end else if (wr.en) begin
      gpr_r[wr.sel] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_base_r  <= gpr_r[rd_base_sel];
      rd_index_r <= gpr_r[rd_index_sel];
    end
  end

  assign rd_base  = rd_base_r;
  assign rd_index = rd_index_r;

endmodule

// File: design/x86am_parser.sv
// Input register and byte parser: tracks ModR/M, SIB and displacement
// bytes and issues an operand record when the operand is complete.
// Depends on x86am_pkg.
module x86am_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  logic                 item_func,
  input  logic [42:0]          item_data,
  input  logic                 rec_free,
  output logic                 rec_load,
  output x86am_pkg::op_rec_t   rec,
  output x86am_pkg::gpr_wr_t   wr
);

  typedef enum logic [1:0] {
    PH_MODRM = 2'd0,
    PH_SIB   = 2'd1,
    PH_DISP  = 2'd2
  } phase_t;

  localparam logic [2:0] REG_ESP = 3'd4;
  localparam logic [2:0] REG_EBP = 3'd5;
  localparam logic [1:0] MOD_REG = 2'd3;

  function automatic logic uses_sib(input logic [7:0] m);
    return (m[7:6] != MOD_REG) && (m[2:0] == REG_ESP);
  endfunction

  function automatic logic [2:0] base_of(input logic [7:0] m, input logic [7:0] s);
    return uses_sib(m) ? s[2:0] : m[2:0];
  endfunction

  function automatic logic [2:0] disp_len(input logic [7:0] m, input logic [7:0] s);
    logic [2:0] len;
    unique case (m[7:6])
      2'd1:    len = 3'd1;
      2'd2:    len = 3'd4;
      default: len = (base_of(m, s) == REG_EBP) ? 3'd4 : 3'd0;
    endcase
    return len;
  endfunction

  function automatic x86am_pkg::op_rec_t make_rec(input logic [7:0] m, input logic [7:0] s,
                                                   input logic [31:0] d, input logic [2:0] cnt);
    x86am_pkg::op_rec_t r;
    logic               mem;
    logic [2:0]         base;
    mem           = (m[7:6] != MOD_REG);
    base          = base_of(m, s);
    r.is_memory   = mem;
    r.reg_field   = m[5:3];
    r.rm_register = mem ? 3'd0 : m[2:0];
    r.byte_length = cnt;
    if (!mem) begin
      r.disp = '0;
    end else if (disp_len(m, s) == 3'd1) begin
      r.disp = {{24{d[7]}}, d[7:0]};
    end else begin
      r.disp = d;
    end
    r.base_en   = mem && !((m[7:6] == 2'd0) && (base == REG_EBP));
    r.base_sel  = base;
    r.index_en  = mem && uses_sib(m) && (s[5:3] != REG_ESP);
    r.index_sel = s[5:3];
    r.scale     = s[7:6];
    return r;
  endfunction

  logic        in_valid_r;
  logic        func_r;
  logic [42:0] data_r;

  phase_t      phase_r,  phase_nxt;
  logic [7:0]  modrm_r,  modrm_nxt;
  logic [7:0]  sib_r,    sib_nxt;
  logic [31:0] disp_r,   disp_nxt;
  logic [2:0]  left_r,   left_nxt;
  logic [2:0]  count_r,  count_nxt;
  logic        emit;
  logic        advance;
  logic [7:0]  b;
  logic [31:0] rec_disp;

  assign advance    = in_valid_r && rec_free;
  assign item_ready = !in_valid_r || rec_free;
  assign b          = data_r[42:35];

  always_comb begin
    logic [2:0] dl;
    logic [2:0] total;
    logic [1:0] pos;
    phase_nxt = phase_r;
    modrm_nxt = modrm_r;
    sib_nxt   = sib_r;
    disp_nxt  = disp_r;
    left_nxt  = left_r;
    count_nxt = count_r;
    emit      = 1'b0;
    rec_disp  = disp_r;
    dl        = 3'd0;
    total     = 3'd0;
    pos       = 2'd0;
    unique case (phase_r)
      PH_SIB: begin
        sib_nxt   = b;
        count_nxt = 3'd2;
        dl        = disp_len(modrm_r, b);
        disp_nxt  = '0;
        rec_disp  = '0;
        if (dl == 3'd0) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_DISP;
          left_nxt  = dl;
        end
      end
      PH_DISP: begin
        total     = disp_len(modrm_r, sib_r);
        pos       = 2'(total - left_r);
        rec_disp  = disp_r | ({24'd0, b} << {pos, 3'b000});
        disp_nxt  = rec_disp;
        left_nxt  = (left_r != 3'd0) ? left_r - 3'd1 : 3'd0;
        count_nxt = count_r + 3'd1;
        emit      = (left_nxt == 3'd0);
      end
      default: begin
        modrm_nxt = b;
        sib_nxt   = '0;
        count_nxt = 3'd1;
        disp_nxt  = '0;
        left_nxt  = 3'd0;
        rec_disp  = '0;
        dl        = disp_len(b, 8'd0);
        if (b[7:6] == MOD_REG) begin
          emit = 1'b1;
        end else if (uses_sib(b)) begin
          phase_nxt = PH_SIB;
        end else if (dl == 3'd0) begin
          emit = 1'b1;
        end else begin
          phase_nxt = PH_DISP;
          left_nxt  = dl;
        end
      end
    endcase
    if (emit) begin
      phase_nxt = PH_MODRM;
      left_nxt  = 3'd0;
      disp_nxt  = '0;
    end
  end

  assign rec      = make_rec(modrm_nxt, sib_nxt, rec_disp, count_nxt);
  assign rec_load = advance && func_r && emit;

  assign wr.en   = advance && !func_r;
  assign wr.sel  = data_r[2:0];
  assign wr.data = data_r[34:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      phase_r    <= PH_MODRM;
      modrm_r    <= '0;
      sib_r      <= '0;
      disp_r     <= '0;
      left_r     <= '0;
      count_r    <= '0;
    end else begin
      if (item_valid && item_ready) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance && func_r) begin
        phase_r <= phase_nxt;
        modrm_r <= modrm_nxt;
        sib_r   <= sib_nxt;
        disp_r  <= disp_nxt;
        left_r  <= left_nxt;
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      func_r <= item_func;
      data_r <= item_data;
    end
  end

endmodule

// File: design/x86am_agen.sv
// Address stage: holds the operand record with its register reads, adds
// base, scaled index and displacement, and drives the output register.
// Depends on x86am_pkg.
module x86am_agen (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         rec_load,
  input  x86am_pkg::op_rec_t           rec,
  input  logic [x86am_pkg::REG_W-1:0]  rd_base,
  input  logic [x86am_pkg::REG_W-1:0]  rd_index,
  output logic                         rec_free,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [47:0]                  out_tdata
);

  x86am_pkg::op_rec_t          rec_r;
  logic                        rec_valid_r;
  logic                        out_valid_r;
  logic [47:0]                 out_data_r;
  logic                        out_free;
  logic [x86am_pkg::REG_W-1:0] base_term;
  logic [x86am_pkg::REG_W-1:0] index_term;
  logic [x86am_pkg::REG_W-1:0] addr;

  assign out_free = !out_valid_r || out_tready;
  assign rec_free = !rec_valid_r || out_free;

  assign base_term  = rec_r.base_en  ? rd_base : '0;
  assign index_term = rec_r.index_en ? (rd_index << rec_r.scale) : '0;
  assign addr       = rec_r.disp + base_term + index_term;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rec_load) begin
        rec_valid_r <= 1'b1;
      end else if (out_free) begin
        rec_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid_r <= rec_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rec_load) begin
      rec_r <= rec;
    end
    if (out_free) begin
      out_data_r <= {6'd0, rec_r.byte_length, addr, rec_r.rm_register,
                     rec_r.reg_field, rec_r.is_memory};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// File: design/x86_modrm_sib_address_decoder.sv
// Top level of the 32-bit ModR/M / SIB effective address decoder.
// Instantiates x86am_parser, x86am_regfile and x86am_agen; uses x86am_pkg.
//
//   channel | dir | payload
//   in_*    | in  | tuser: func; tdata: register_number, register_value, code_byte
//   out_*   | out | tdata: is_memory, reg_field, rm_register, address, byte_length
//
// One request per cycle is taken while out_tready does not stall; a completed
// operand passes the input register, the operand register with the register
// reads and the output register with the add before it is on out_*.
// Register writes and non-final bytes give no result.
// rst_n is synchronous: parse state, valids and the register copy clear to zero.
// A stalled out_tready backs up through the stages to in_tready.
module x86_modrm_sib_address_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic        in_tuser,   // func
  input  logic [47:0] in_tdata,   // register_number[2:0], register_value[34:3], code_byte[42:35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // is_memory[0], reg_field[3:1], rm_register[6:4],
                                  // address[38:7], byte_length[41:39]
);

  x86am_pkg::op_rec_t          rec;
  x86am_pkg::gpr_wr_t          wr;
  logic                        rec_load;
  logic                        rec_free;
  logic [x86am_pkg::REG_W-1:0] rd_base;
  logic [x86am_pkg::REG_W-1:0] rd_index;

  x86am_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item_func  (in_tuser),
    .item_data  (in_tdata[42:0]),
    .rec_free   (rec_free),
    .rec_load   (rec_load),
    .rec        (rec),
    .wr         (wr)
  );

  x86am_regfile u_regfile (
    .clk          (clk),
    .rst_n        (rst_n),
    .wr           (wr),
    .rd_en        (rec_load),
    .rd_base_sel  (rec.base_sel),
    .rd_index_sel (rec.index_sel),
    .rd_base      (rd_base),
    .rd_index     (rd_index)
  );

  x86am_agen u_agen (
    .clk        (clk),
    .rst_n      (rst_n),
    .rec_load   (rec_load),
    .rec        (rec),
    .rd_base    (rd_base),
    .rd_index   (rd_index),
    .rec_free   (rec_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    rec_load |-> rec_free)
    else $error("operand record loaded over an undelivered one");

  a_no_write_with_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(rec_load && wr.en))
    else $error("register write and operand completion in one cycle");

  a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[41:39] != 3'd0 && out_tdata[41:39] != 3'd7))
    else $error("byte length out of range");

  a_reg_operand_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[0]) |-> (out_tdata[38:7] == 32'd0 && out_tdata[41:39] == 3'd1))
    else $error("register operand with address or extra bytes");

endmodule
